// ===== rtl/core/rcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and double-precision helpers for the range-checked conversion unit.
package rcc_pkg;

    typedef logic [63:0] dbl_t;

    // Conversion kinds
    localparam logic [2:0] KIND_SS = 3'd0;  // signed <- signed
    localparam logic [2:0] KIND_US = 3'd1;  // unsigned <- signed
    localparam logic [2:0] KIND_SU = 3'd2;  // signed <- unsigned
    localparam logic [2:0] KIND_UU = 3'd3;  // unsigned <- unsigned
    localparam logic [2:0] KIND_SD = 3'd4;  // signed <- double
    localparam logic [2:0] KIND_UD = 3'd5;  // unsigned <- double

    localparam dbl_t DBL_SIGN      = 64'h8000_0000_0000_0000;
    localparam dbl_t DBL_ONE       = 64'h3FF0_0000_0000_0000;
    localparam dbl_t DBL_NEG_ONE   = 64'hBFF0_0000_0000_0000;
    localparam dbl_t DBL_TWO63     = 64'h43E0_0000_0000_0000;
    localparam dbl_t DBL_NEG_TWO63 = 64'hC3E0_0000_0000_0000;
    localparam dbl_t DBL_TWO64     = 64'h43F0_0000_0000_0000;

    function automatic logic dbl_is_nan(input dbl_t x);
        return (&x[62:52]) && (|x[51:0]);
    endfunction

    // Monotonic ordering key; both zeros map to the same key
    function automatic dbl_t dbl_key(input dbl_t x);
        dbl_t c;
        c = (x[62:0] == 63'd0) ? 64'd0 : x;
        return c[63] ? ~c : (c ^ DBL_SIGN);
    endfunction

    // Ordered less-than; false whenever either side is NaN
    function automatic logic dbl_lt(input dbl_t a, input dbl_t b);
        return !dbl_is_nan(a) && !dbl_is_nan(b) && (dbl_key(a) < dbl_key(b));
    endfunction

endpackage

// ===== rtl/core/range_checked_conversion.sv =====
`timescale 1ns / 1ps
// Top level of the range-checked integer and double to integer conversion unit.
//
// Usage:
//   Slave channel s_*: one transaction per conversion. s_tuser carries the kind,
//   s_tdata the source value and the two bound patterns.
//   Master channel m_*: one transaction per conversion, in order. m_tdata is the
//   converted pattern (zero on failure), m_tuser the overflow flag.
// Latency: six register stages, the first loaded at the accepting edge and the last
//   driving m_tvalid, m_tdata and m_tuser.
// Throughput: one conversion per cycle while m_tready holds high; the rounded bound
//   adders (bound plus or minus one, five stages each) set the pipeline depth, not the rate.
// Stalls: every stage carries its own valid bit and holds while the stage ahead
//   is full, so bubbles are squeezed out and input keeps flowing until all six
//   stages are occupied; nothing is dropped or repeated.
// Reset: rst_n clears all valid bits, the unit is empty and ready at once.
module range_checked_conversion (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // value[63:0], lower_bound[127:64], upper_bound[191:128]
    input  logic [2:0]   s_tuser,   // kind[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // converted[63:0]
    output logic [0:0]   m_tuser    // overflow[0]
);
    import rcc_pkg::*;

    // Checks settled in the first stage and carried along
    typedef struct packed {
        logic int_fail;
        logic ge_m63;
        logic lt_63;
        logic lt_64;
        logic gt_m1;
        logic le_zero;
    } chk_t;

    dbl_t v_in;
    dbl_t lo_in;
    dbl_t hi_in;
    logic [2:0] kind_in;

    assign v_in    = s_tdata[63:0];
    assign lo_in   = s_tdata[127:64];
    assign hi_in   = s_tdata[191:128];
    assign kind_in = s_tuser;

    // Stage advance: a stage loads when it is empty or the one ahead moves on
    logic [6:1] adv;
    logic [6:1] valid_reg;

    always_comb
    begin
        adv[6] = !valid_reg[6] || m_tready;
        for (int i = 5; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= s_tvalid;
            end
            for (int i = 2; i <= 6; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // First stage checks: integer bounds and fixed double limits
    chk_t chk_next;

    always_comb
    begin
        chk_next = '0;
        case (kind_in)
            KIND_SS:
            begin
                chk_next.int_fail = ((v_in ^ DBL_SIGN) < (lo_in ^ DBL_SIGN))
                                 || ((hi_in ^ DBL_SIGN) < (v_in ^ DBL_SIGN));
            end
            KIND_US: chk_next.int_fail = v_in[63] || (v_in > hi_in);
            KIND_SU: chk_next.int_fail = hi_in[63] || (v_in > hi_in);
            KIND_UU: chk_next.int_fail = v_in > hi_in;
            default: chk_next.int_fail = 1'b0;
        endcase
        chk_next.ge_m63  = !dbl_is_nan(v_in) && !dbl_lt(v_in, DBL_NEG_TWO63);
        chk_next.lt_63   = dbl_lt(v_in, DBL_TWO63);
        chk_next.lt_64   = dbl_lt(v_in, DBL_TWO64);
        chk_next.gt_m1   = dbl_lt(DBL_NEG_ONE, v_in);
        chk_next.le_zero = v_in[63] || (v_in[62:0] == 63'd0);
    end

    // Carry kind, value and checks alongside the arithmetic units
    logic [2:0] kind_reg [1:5];
    dbl_t       v_reg    [1:5];
    chk_t       chk_reg  [1:5];
    logic [63:0] t_reg   [3:5];
    logic [63:0] t_out;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            kind_reg[1] <= kind_in;
            v_reg[1]    <= v_in;
            chk_reg[1]  <= chk_next;
        end
        for (int i = 2; i <= 5; i++)
        begin
            if (adv[i])
            begin
                kind_reg[i] <= kind_reg[i-1];
                v_reg[i]    <= v_reg[i-1];
                chk_reg[i]  <= chk_reg[i-1];
            end
        end
        if (adv[3])
        begin
            t_reg[3] <= t_out;
        end
        for (int i = 4; i <= 5; i++)
        begin
            if (adv[i])
            begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    // Rounded bounds: hi + 1 directly, lo - 1 as -((-lo) + 1)
    dbl_t hp;
    dbl_t lo_neg_inc;
    dbl_t lm;

    rcc_inc u_inc_hi (
        .clk (clk),
        .adv (adv[5:1]),
        .x   (hi_in),
        .y   (hp)
    );

    rcc_inc u_inc_lo (
        .clk (clk),
        .adv (adv[5:1]),
        .x   ({~lo_in[63], lo_in[62:0]}),
        .y   (lo_neg_inc)
    );

    assign lm = {~lo_neg_inc[63], lo_neg_inc[62:0]};

    rcc_trunc u_trunc (
        .clk (clk),
        .adv (adv[2:1]),
        .d   (v_in),
        .t   (t_out)
    );

    // Final decision and result register
    logic        fail;
    logic [63:0] res;
    logic [63:0] conv_reg;
    logic        ovf_reg;

    always_comb
    begin
        fail = 1'b1;
        res  = 64'd0;
        case (kind_reg[5]) inside
            KIND_SS, KIND_US, KIND_SU, KIND_UU:
            begin
                fail = chk_reg[5].int_fail;
                res  = v_reg[5];
            end
            KIND_SD:
            begin
                fail = !(dbl_lt(lm, v_reg[5]) && dbl_lt(v_reg[5], hp)
                         && chk_reg[5].ge_m63 && chk_reg[5].lt_63);
                res  = t_reg[5];
            end
            KIND_UD:
            begin
                fail = !(chk_reg[5].gt_m1 && dbl_lt(v_reg[5], hp) && chk_reg[5].lt_64);
                res  = chk_reg[5].le_zero ? 64'd0 : t_reg[5];
            end
            default:
            begin
                fail = 1'b1;
                res  = 64'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            conv_reg <= fail ? 64'd0 : res;
            ovf_reg  <= fail;
        end
    end

    assign m_tvalid   = valid_reg[6];
    assign m_tdata    = conv_reg;
    assign m_tuser[0] = ovf_reg;

endmodule

// ===== rtl/core/rcc_inc.sv =====
`timescale 1ns / 1ps
// Five-stage pipeline that forms the rounded double sum x + 1.0 (round to nearest even).
module rcc_inc (
    input  logic          clk,
    input  logic [4:0]    adv,
    input  rcc_pkg::dbl_t x,
    output rcc_pkg::dbl_t y
);
    import rcc_pkg::*;

    // Fixed point with 107 fraction bits covers every exponent in the exact window
    localparam int FXW = 163;
    localparam logic [FXW-1:0] ONE_FX = {55'd0, 1'b1, 107'd0};
    localparam logic [10:0] WIN_LO = 11'd969;
    localparam logic [10:0] WIN_HI = 11'd1076;

    // Stage 1: align the significand
    logic [10:0]    e_in;
    logic [10:0]    shd;
    logic [FXW-1:0] a_next;
    logic [FXW-1:0] a_reg;
    logic           sgn1_reg;
    logic           win1_reg;
    logic           pass1_reg;
    dbl_t           x1_reg;

    assign e_in   = x[62:52];
    assign shd    = e_in - 11'd968;
    assign a_next = {110'd0, 1'b1, x[51:0]} << shd[6:0];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_reg     <= a_next;
            sgn1_reg  <= x[63];
            win1_reg  <= (e_in >= WIN_LO) && (e_in <= WIN_HI);
            pass1_reg <= e_in > WIN_HI;
            x1_reg    <= x;
        end
    end

    // Stage 2: exact add or subtract of one
    logic [FXW-1:0] v_next;
    logic           neg_next;
    logic [FXW-1:0] v2_reg;
    logic           neg2_reg;
    logic           win2_reg;
    logic           pass2_reg;
    dbl_t           x2_reg;

    always_comb
    begin
        neg_next = 1'b0;
        if (!sgn1_reg)
        begin
            v_next = a_reg + ONE_FX;
        end
        else if (a_reg >= ONE_FX)
        begin
            v_next   = a_reg - ONE_FX;
            neg_next = a_reg != ONE_FX;
        end
        else
        begin
            v_next = ONE_FX - a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            v2_reg    <= v_next;
            neg2_reg  <= neg_next;
            win2_reg  <= win1_reg;
            pass2_reg <= pass1_reg;
            x2_reg    <= x1_reg;
        end
    end

    // Stage 3: find the leading one
    logic [7:0]     p_next;
    logic [FXW-1:0] v3_reg;
    logic [7:0]     p3_reg;
    logic           zero3_reg;
    logic           neg3_reg;
    logic           win3_reg;
    logic           pass3_reg;
    dbl_t           x3_reg;

    always_comb
    begin
        p_next = 8'd0;
        for (int i = 0; i < FXW; i++)
        begin
            if (v2_reg[i])
            begin
                p_next = 8'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            v3_reg    <= v2_reg;
            p3_reg    <= p_next;
            zero3_reg <= v2_reg == '0;
            neg3_reg  <= neg2_reg;
            win3_reg  <= win2_reg;
            pass3_reg <= pass2_reg;
            x3_reg    <= x2_reg;
        end
    end

    // Stage 4: normalise, split into significand, guard and sticky
    logic [FXW-1:0] n_next;
    logic [52:0]    mant4_reg;
    logic           grd4_reg;
    logic           stk4_reg;
    logic [10:0]    be4_reg;
    logic           zero4_reg;
    logic           neg4_reg;
    logic           win4_reg;
    logic           pass4_reg;
    dbl_t           x4_reg;

    assign n_next = v3_reg << (8'd162 - p3_reg);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            mant4_reg <= n_next[162:110];
            grd4_reg  <= n_next[109];
            stk4_reg  <= |n_next[108:0];
            be4_reg   <= {3'd0, p3_reg} + 11'd916;
            zero4_reg <= zero3_reg;
            neg4_reg  <= neg3_reg;
            win4_reg  <= win3_reg;
            pass4_reg <= pass3_reg;
            x4_reg    <= x3_reg;
        end
    end

    // Stage 5: round to nearest even and pack
    logic        up;
    logic [53:0] sum;
    logic [10:0] be_next;
    logic [51:0] frac_next;
    dbl_t        y_next;
    dbl_t        y_reg;

    always_comb
    begin
        up        = grd4_reg & (stk4_reg | mant4_reg[0]);
        sum       = {1'b0, mant4_reg} + {53'd0, up};
        be_next   = sum[53] ? be4_reg + 11'd1 : be4_reg;
        frac_next = sum[53] ? 52'd0 : sum[51:0];
        if (pass4_reg)
        begin
            y_next = x4_reg;
        end
        else if (!win4_reg)
        begin
            y_next = DBL_ONE;
        end
        else if (zero4_reg)
        begin
            y_next = 64'd0;
        end
        else
        begin
            y_next = {neg4_reg, be_next, frac_next};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/core/rcc_trunc.sv =====
`timescale 1ns / 1ps
// Two-stage truncation of a double toward zero into a 64-bit two's complement pattern.
module rcc_trunc (
    input  logic          clk,
    input  logic [1:0]    adv,
    input  rcc_pkg::dbl_t d,
    output logic [63:0]   t
);
    import rcc_pkg::*;

    logic [10:0] e_in;
    logic [10:0] shd;
    logic [63:0] mag_next;
    logic [63:0] mag_reg;
    logic        sgn_reg;
    logic [63:0] t_reg;

    assign e_in = d[62:52];
    assign shd  = 11'd1086 - e_in;

    always_comb
    begin
        if ((e_in < 11'd1023) || (e_in > 11'd1086))
        begin
            mag_next = 64'd0;
        end
        else
        begin
            mag_next = {1'b1, d[51:0], 11'd0} >> shd[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mag_reg <= mag_next;
            sgn_reg <= d[63];
        end
        if (adv[1])
        begin
            t_reg <= sgn_reg ? (64'd0 - mag_reg) : mag_reg;
        end
    end

    assign t = t_reg;

endmodule

// ===== tb/range_checked_conversion_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each conversion result and compares it with the master channel.
module range_checked_conversion_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           failures,
    output int           pending
);
    import rcc_pkg::*;

    typedef struct packed {
        logic [63:0] converted;
        logic        overflow;
    } conv_result_t;

    localparam real TWO63 = 9223372036854775808.0;
    localparam real TWO64 = 18446744073709551616.0;

    conv_result_t result_q[$];

    // Magnitude of a double truncated toward zero; valid below 2^64
    function automatic logic [63:0] truncated_magnitude(input dbl_t x);
        int          e;
        logic [63:0] m;
        e = int'(x[62:52]);
        m = {11'd0, 1'b1, x[51:0]};
        if (e < 1023)
            return 64'd0;
        if (e >= 1075)
            return m << (e - 1075);
        return m >> (1075 - e);
    endfunction

    function automatic conv_result_t predict_conversion(input logic [2:0] kind,
                                                        input logic [63:0] v,
                                                        input logic [63:0] lo,
                                                        input logic [63:0] hi);
        conv_result_t r;
        real          d;
        real          dl;
        real          dh;
        logic [63:0]  mag;
        logic         fail;
        d    = $bitstoreal(v);
        dl   = $bitstoreal(lo);
        dh   = $bitstoreal(hi);
        mag  = truncated_magnitude(v);
        fail = 1'b0;
        r.converted = v;
        case (kind)
            KIND_SS: fail = ($signed(v) < $signed(lo)) || ($signed(hi) < $signed(v));
            KIND_US: fail = v[63] || (v > hi);
            KIND_SU: fail = hi[63] || (v > hi);
            KIND_UU: fail = v > hi;
            KIND_SD:
            begin
                if (d > dl - 1.0 && d < dh + 1.0 && d >= -TWO63 && d < TWO63)
                    r.converted = v[63] ? -mag : mag;
                else
                    fail = 1'b1;
            end
            KIND_UD:
            begin
                if (d > -1.0 && d < dh + 1.0 && d < TWO64)
                    r.converted = (d <= 0.0) ? 64'd0 : mag;
                else
                    fail = 1'b1;
            end
            default: fail = 1'b1;
        endcase
        if (fail)
            r.converted = 64'd0;
        r.overflow = fail;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s got %h, want %h", $time, what, got, want);
        failures++;
    endtask

    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n)
        begin
            // Queue the prediction for each input transaction
            if (s_tvalid && s_tready)
                result_q.push_back(predict_conversion(s_tuser, s_tdata[63:0],
                                                      s_tdata[127:64], s_tdata[191:128]));
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 64'd0);
                else
                begin
                    want = result_q.pop_front();
                    if (m_tdata !== want.converted)
                        report_mismatch("converted", m_tdata, want.converted);
                    if (m_tuser[0] !== want.overflow)
                        report_mismatch("overflow", {63'd0, m_tuser[0]},
                                        {63'd0, want.overflow});
                end
            end
        end
        pending = result_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, stimulus and verdict for the conversion unit.
module tb;
    import rcc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // value[63:0], lower_bound[127:64], upper_bound[191:128]
    logic [2:0]   s_tuser;   // kind[2:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // converted[63:0]
    logic [0:0]   m_tuser;   // overflow[0]
    int           failures;
    int           pending;
    logic         calm;      // high during the stretch with no idling on either side

    localparam dbl_t DBL_POS_INF = 64'h7FF0_0000_0000_0000;
    localparam dbl_t DBL_NEG_INF = 64'hFFF0_0000_0000_0000;
    localparam dbl_t DBL_NAN     = 64'h7FF8_0000_0000_0001;
    localparam dbl_t DBL_HALF    = 64'h3FE0_0000_0000_0000;
    localparam dbl_t DBL_NEG_0   = 64'h8000_0000_0000_0000;

    range_checked_conversion DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    range_checked_conversion_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: stall about a quarter of the cycles, never while calm
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 24);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Small signed integer, optionally with a quarter-step fraction, as a double
    function automatic dbl_t small_dbl(input int span);
        real x;
        x = real'(int'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 1))
            x = x + real'(int'($urandom_range(0, 7)) - 4) * 0.25;
        return $realtobits(x);
    endfunction

    function automatic dbl_t special_dbl();
        case ($urandom_range(0, 9))
            0: return DBL_NAN;
            1: return DBL_POS_INF;
            2: return DBL_NEG_INF;
            3: return DBL_NEG_0;
            4: return DBL_TWO63;
            5: return DBL_NEG_TWO63;
            6: return DBL_TWO64;
            7: return DBL_NEG_ONE;
            8: return DBL_HALF | DBL_SIGN;
            default: return 64'd0;
        endcase
    endfunction

    // Source double: mostly near the bounds or small, sometimes huge or special
    function automatic dbl_t pick_source_dbl(input dbl_t lo, input dbl_t hi);
        real off;
        off = real'(int'($urandom_range(0, 8)) - 4) * 0.25;
        case ($urandom_range(0, 9))
            0, 1: return $realtobits($bitstoreal(hi) + 1.0 + off);
            2, 3: return $realtobits($bitstoreal(lo) - 1.0 + off);
            4:    return $realtobits(real'($signed(rand64())));
            5:    return $realtobits(real'(rand64()));
            6:    return rand64();
            7:    return special_dbl();
            default: return small_dbl(1200);
        endcase
    endfunction

    // Wait for the handshake: sample tready at the falling edge, advance at the rising
    task automatic send_item(input logic [2:0] kind, input logic [63:0] v,
                             input logic [63:0] lo, input logic [63:0] hi);
        logic taken;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {hi, lo, v};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_random_item();
        logic [2:0]  kind;
        logic [63:0] v;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] t;
        kind = 3'($urandom_range(0, 5));
        if (kind == KIND_SD || kind == KIND_UD)
        begin
            // Double bounds: mostly small, now and then huge or special
            lo = ($urandom_range(0, 7) == 0) ? special_dbl() : small_dbl(1000);
            hi = ($urandom_range(0, 7) == 0) ? special_dbl() : small_dbl(1000);
            if ($urandom_range(0, 7) == 0)
                lo = rand64();
            v = pick_source_dbl(lo, hi);
        end
        else
        begin
            lo = rand64();
            hi = rand64();
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    lo = 64'(int'($urandom_range(0, 2000)) - 1000);
                    hi = 64'(int'($urandom_range(0, 2000)) - 1000);
                end
                2: hi = {1'b0, hi[62:0]};
                default: hi = {1'b1, hi[62:0]};
            endcase
            // Keep the signed range ordered most of the time
            if ($urandom_range(0, 4) != 0 && $signed(hi) < $signed(lo))
            begin
                t  = hi;
                hi = lo;
                lo = t;
            end
            case ($urandom_range(0, 5))
                0:       v = rand64();
                1, 2:    v = hi + 64'(int'($urandom_range(0, 4)) - 2);
                3:       v = lo + 64'(int'($urandom_range(0, 4)) - 2);
                default: v = lo + (rand64() % ((hi - lo) | 64'd1));
            endcase
        end
        send_item(kind, v, lo, hi);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_SS;
        calm     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: integer extremes
        send_item(KIND_SS, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_SS, 64'hFFFF_FFFF_FFFF_FFF6, 64'hFFFF_FFFF_FFFF_FFF7, 64'd5);
        send_item(KIND_SS, 64'd6, 64'hFFFF_FFFF_FFFF_FFF7, 64'd5);
        send_item(KIND_US, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_US, 64'd100, 64'd0, 64'd99);
        send_item(KIND_US, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        // Negative signed bound for an unsigned source: always fails
        send_item(KIND_SU, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_SU, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_UU, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_UU, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        // Directed: doubles, truncation and the special values
        send_item(KIND_SD, $realtobits(-1.75), $realtobits(-2.0), $realtobits(2.0));
        send_item(KIND_SD, $realtobits(2.99), $realtobits(-2.0), $realtobits(2.0));
        send_item(KIND_SD, DBL_NAN, DBL_NEG_INF, DBL_POS_INF);
        send_item(KIND_SD, DBL_POS_INF, DBL_NEG_INF, DBL_POS_INF);
        send_item(KIND_SD, DBL_NEG_TWO63, DBL_NEG_INF, DBL_POS_INF);
        send_item(KIND_SD, DBL_TWO63, DBL_NEG_INF, DBL_POS_INF);
        send_item(KIND_SD, DBL_ONE, DBL_NAN, DBL_POS_INF);
        // Unsigned target in (-1, 0] gives zero
        send_item(KIND_UD, DBL_HALF | DBL_SIGN, 64'd0, DBL_ONE);
        send_item(KIND_UD, DBL_NEG_0, 64'd0, DBL_ONE);
        send_item(KIND_UD, DBL_NEG_ONE, 64'd0, DBL_ONE);
        send_item(KIND_UD, DBL_TWO64, 64'd0, DBL_POS_INF);
        send_item(KIND_UD, 64'h43EF_FFFF_FFFF_FFFF, 64'd0, DBL_POS_INF);
        send_item(KIND_UD, DBL_NEG_INF, 64'd0, DBL_POS_INF);

        for (int i = 0; i < 1550; i++)
        begin
            calm <= (i >= 600 && i < 800);
            // Hold off until the pipeline is empty once
            if (i == 1000)
            begin
                s_tvalid <= 1'b0;
                drain();
            end
            if (!(i >= 600 && i < 800) && $urandom_range(0, 99) < 24)
                idle_cycles($urandom_range(1, 3));
            send_random_item();
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
